FILE: rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg - shared definitions for the integer list sorter
// Store geometry, sequencer state codes and the store request bundle.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_CMP  = 5'b00100,
    ST_RD   = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  // One write and one read request to the element store per cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

endpackage

FILE: rtl/ils_store.sv
// ----------------------------------------------------------------------------
// ils_store - element store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module ils_store (
  input  logic                        clk,
  input  ils_pkg::store_req_t         req,
  output logic [ils_pkg::DATA_W-1:0]  rd_data
);
  import ils_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // Write and read in the same clocked block
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

FILE: rtl/ils_cmp.sv
// ----------------------------------------------------------------------------
// ils_cmp - shared signed comparator
// Flags when the stored word orders above the word being inserted.
// ----------------------------------------------------------------------------
module ils_cmp (
  input  logic [ils_pkg::DATA_W-1:0] stored,
  input  logic [ils_pkg::DATA_W-1:0] cand,
  output logic                       greater
);
  import ils_pkg::*;

  // Signed order as an unsigned compare with the sign bits flipped
  logic [DATA_W-1:0] key_s;
  logic [DATA_W-1:0] key_c;

  assign key_s   = {~stored[DATA_W-1], stored[DATA_W-2:0]};
  assign key_c   = {~cand[DATA_W-1], cand[DATA_W-2:0]};
  assign greater = key_s > key_c;

endmodule

FILE: rtl/integer_list_sorter_unit.sv
// ----------------------------------------------------------------------------
// integer_list_sorter_unit - ascending sorter for lists of signed words
// Keeps the store sorted by insertion as beats arrive; on the closing beat
// the whole list streams out in ascending signed order.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                  | tlast
//  in_     | in  | [31:0] value           | last_in
//  out_    | out | [31:0] sorted_value    | last_out
//
//  Insertion: after an input beat is accepted, the sequencer steps down from
//  the top of the list once for every stored entry greater than the new
//  value; each step of the insertion is one store read and one comparator
//  decision, and in_tready returns once the sequencer is back in idle.
//  Output: each result beat is a store read, then a hold until taken.
//  Reset clears the sequencer state and the fill count; the store needs no
//  clearing pass.
//  in_tready is low while an insertion or an output run is in progress;
//  a stalled out_ beat holds its data.
// ----------------------------------------------------------------------------
module integer_list_sorter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,   // last_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast   // last_out
);
  import ils_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;    // insertion slot or output index
  logic [DATA_W-1:0] cur_r, cur_nxt;
  logic              last_r, last_nxt;
  logic [CNT_W-1:0]  pos_m1;
  logic [DATA_W-1:0] rd_data;
  logic              greater;
  logic              out_fin;
  store_req_t        req;

  ils_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  ils_cmp u_cmp (
    .stored  (rd_data),
    .cand    (cur_r),
    .greater (greater)
  );

  assign pos_m1     = pos_r - 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = rd_data;
  assign out_tlast  = ((pos_r + 1'b1) == count_r);
  assign out_fin    = out_tvalid && out_tready && out_tlast;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    cur_nxt   = cur_r;
    last_nxt  = last_r;
    req.we    = 1'b0;
    req.waddr = pos_r[ADDR_W-1:0];
    req.wdata = cur_r;
    req.re    = 1'b0;
    req.raddr = pos_m1[ADDR_W-1:0];
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cur_nxt  = in_tdata;
          last_nxt = in_tlast;
          if (count_r < CNT_W'(DEPTH)) begin
            pos_nxt   = count_r;
            state_nxt = ST_SCAN;
          end else if (in_tlast) begin
            // store full: drop the value, still emit the list
            pos_nxt   = '0;
            state_nxt = ST_RD;
          end
        end
      end
      ST_SCAN: begin
        if (pos_r == '0) begin
          req.we    = 1'b1;
          count_nxt = count_r + 1'b1;
          pos_nxt   = '0;
          state_nxt = last_r ? ST_RD : ST_IDLE;
        end else begin
          req.re    = 1'b1;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        req.we = 1'b1;
        if (greater) begin
          // shift the larger neighbor up one slot
          req.wdata = rd_data;
          pos_nxt   = pos_m1;
          state_nxt = ST_SCAN;
        end else begin
          count_nxt = count_r + 1'b1;
          pos_nxt   = '0;
          state_nxt = last_r ? ST_RD : ST_IDLE;
        end
      end
      ST_RD: begin
        req.re    = 1'b1;
        req.raddr = pos_r[ADDR_W-1:0];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) begin
          if (out_tlast) begin
            count_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt   = pos_r + 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    cur_r  <= cur_nxt;
    last_r <= last_nxt;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_fin |=> (count_r == '0) && in_tready)
    else $error("store not emptied after final result");

  a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (count_r != '0) && (pos_r < count_r))
    else $error("result beat outside stored list");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken during output run");

endmodule

FILE: tb/list_order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_order_checker - scoreboard for the integer list sorter
// Watches both stream channels, collects each open list from the accepted
// input beats, works out the ascending order when the closing beat lands and
// compares every result beat against it, value and end-of-run flag.
// ----------------------------------------------------------------------------
module list_order_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,   // last_in
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] sorted_value
  input  logic        out_tlast,  // last_out
  output int          mismatches,
  output int          awaited,
  output int          results_seen
);
  import ils_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } sorted_beat_t;

  // Values of the list still being collected, and the sorted beats due out
  logic signed [DATA_W-1:0] open_list[$];
  sorted_beat_t             sorted_due[$];

  always @(posedge clk) begin : track
    logic signed [DATA_W-1:0] pick;
    sorted_beat_t             want;
    int                       j;
    if (!rst_n) begin
      open_list.delete();
      sorted_due.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      // Check a result beat against the oldest due beat
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (sorted_due.size() == 0) begin
          $display("%0t: unexpected result beat value %0d last %0b",
                   $time, $signed(out_tdata), out_tlast);
          mismatches++;
        end else begin
          want = sorted_due.pop_front();
          if (out_tdata !== want.value) begin
            $display("%0t: sorted_value expected %0d actual %0d",
                     $time, $signed(want.value), $signed(out_tdata));
            mismatches++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last_out expected %0b actual %0b",
                     $time, want.last, out_tlast);
            mismatches++;
          end
        end
      end

      // Collect an input beat; drop it when the store is already full
      if (in_tvalid && in_tready) begin
        if (open_list.size() < DEPTH)
          open_list.push_back(in_tdata);
        if (in_tlast) begin
          // Order the list by signed value, then queue it with the final flag
          for (int i = 1; i < open_list.size(); i++) begin
            pick = open_list[i];
            j = i;
            while (j > 0 && open_list[j-1] > pick) begin
              open_list[j] = open_list[j-1];
              j--;
            end
            open_list[j] = pick;
          end
          for (int i = 0; i < open_list.size(); i++) begin
            want.value = open_list[i];
            want.last  = (i == open_list.size() - 1);
            sorted_due.push_back(want);
          end
          open_list.delete();
        end
      end
    end
    awaited = sorted_due.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - stimulus and verdict for the integer list sorter
// Sends directed and random lists of signed words with random gaps on both
// channels, a long receiver hold-off and drain pauses; the list_order_checker
// beside the block predicts and compares every sorted beat.
// ----------------------------------------------------------------------------
module tb_top;
  import ils_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int ITEM_GOAL    = 410;
  localparam int IDLE_PCT     = 28;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;
  logic        out_tlast;

  int mismatches;
  int awaited;
  int results_seen;
  int quiet_cycles = 0;
  int items_sent = 0;
  int lists_sent = 0;
  int hold_ticket = 0;
  int hold_served = 0;
  bit calm = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  integer_list_sorter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  list_order_checker order_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .mismatches   (mismatches),
    .awaited      (awaited),
    .results_seen (results_seen)
  );

  // Offer one beat after random idle cycles, hold it until taken
  task automatic send_value(input logic [31:0] v, input logic l);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid = 1'b0;
      in_tdata  = $urandom;
      in_tlast  = 1'($urandom_range(1));
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = v;
    in_tlast  = l;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
    items_sent++;
    if (l)
      lists_sent++;
  endtask

  // Hold the sender until every sorted beat has come back
  task automatic wait_drained();
    @(negedge clk);
    while (awaited != 0)
      @(negedge clk);
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_served != hold_ticket) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_served = hold_ticket;
      end else begin
        out_tready = calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog on cycles with no beat accepted on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("integer_list_sorter_unit verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] v;
    int          len;
    int          list_idx;
    int          rand_items;

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed: single element at the minimum
    send_value(32'h8000_0000, 1'b1);
    // Directed: field extremes in mixed order
    send_value(32'h7fff_ffff, 1'b0);
    send_value(32'h8000_0000, 1'b0);
    send_value(32'h0000_0000, 1'b0);
    send_value(32'hffff_ffff, 1'b0);
    send_value(32'h0000_0001, 1'b1);
    wait_drained();
    // Directed: repeated values
    send_value(32'd7, 1'b0);
    send_value(-32'sd7, 1'b0);
    send_value(32'd7, 1'b0);
    send_value(32'd7, 1'b1);
    // Directed: descending list, deepest insertion per beat
    send_value(32'd40, 1'b0);
    send_value(32'd30, 1'b0);
    send_value(32'd20, 1'b0);
    send_value(32'd10, 1'b1);
    // Directed: already ascending, then a lone maximum
    send_value(-32'sd3, 1'b0);
    send_value(-32'sd2, 1'b0);
    send_value(-32'sd1, 1'b1);
    send_value(32'h7fff_ffff, 1'b1);

    // Random lists: mostly short, some full-depth and some overflowing
    list_idx   = 0;
    rand_items = 0;
    while (rand_items < ITEM_GOAL) begin
      case (list_idx)
        2:       len = DEPTH;
        4:       len = DEPTH + 1;
        6:       len = DEPTH + 6;
        default: len = ($urandom_range(99) < 6) ? $urandom_range(DEPTH, 50)
                                                : $urandom_range(16, 1);
      endcase
      calm = (list_idx >= 10 && list_idx < 15);
      for (int e = 0; e < len; e++) begin
        case ($urandom_range(9))
          0: begin
            case ($urandom_range(4))
              0:       v = 32'h8000_0000;
              1:       v = 32'h7fff_ffff;
              2:       v = 32'h0000_0000;
              3:       v = 32'hffff_ffff;
              default: v = 32'h0000_0001;
            endcase
          end
          1, 2:    v = $urandom_range(8) - 4;
          default: v = $urandom;
        endcase
        // Stall the output of the full list so the next one backs up
        if (list_idx == 2 && e == len - 1)
          hold_ticket++;
        send_value(v, e == len - 1);
        rand_items++;
      end
      if (list_idx == 8)
        wait_drained();
      list_idx++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Summary: %0d lists, %0d values sent, %0d sorted beats compared;",
             lists_sent, items_sent, results_seen);
    $display("  covered extremes, repeats, full and overflowing lists, long output hold");
    if (mismatches == 0) begin
      $display("integer_list_sorter_unit verification clean");
    end else begin
      $display("integer_list_sorter_unit verification failed");
    end
    $finish;
  end

endmodule
